// ===== rtl/line_literal_pattern_search_top_assert.svh =====
// Assertion macros used by the top-level file to check this block.
`ifndef LINE_LITERAL_PATTERN_SEARCH_TOP_ASSERT_SVH
`define LINE_LITERAL_PATTERN_SEARCH_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LLPS_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold whenever its antecedent holds.
`define LLPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/llps_pkg.sv =====
package llps_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_LINE_DEF    = 4096;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CHAR_W    = 8;
  localparam int BOUND_W   = 13;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 12;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

  typedef struct packed {
    logic line_start;
    logic line_end;
    logic backward;
    logic hit;
  } llps_ctl_t;

  typedef struct packed {
    llps_ctl_t          ctl;
    logic [BOUND_W-1:0] bound;
    logic [ROW_W-1:0]   row;
  } llps_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } llps_qstat_t;

  // Byte k of the pattern; bytes beyond the sixteen held read as zero.
  function automatic logic [CHAR_W-1:0] pattern_byte(input logic [LEN_W-1:0] k,
                                                     input logic [CFG_DAT_W-1:0] lo,
                                                     input logic [CFG_DAT_W-1:0] hi);
    logic [CHAR_W-1:0] b;
    if (k < LEN_W'(8)) begin
      b = lo[{k[2:0], 3'b000} +: CHAR_W];
    end else if (k < LEN_W'(16)) begin
      b = hi[{k[2:0], 3'b000} +: CHAR_W];
    end else begin
      b = '0;
    end
    return b;
  endfunction

endpackage

// ===== rtl/llps_front.sv =====
module llps_front import llps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_LINE    = MAX_LINE_DEF,
  localparam int COL_W      = $clog2(MAX_LINE + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char_byte,
  input  logic                 in_has_byte,
  input  logic                 in_line_start,
  input  logic                 in_line_end,
  input  logic                 in_backward,
  input  logic [BOUND_W-1:0]   in_bound_col,
  input  logic [ROW_W-1:0]     in_row_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output llps_item_t           push_item,
  output logic [COL_W-1:0]     push_col
);

  localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [LEN_W-1:0]     pat_len_r;
  logic [CFG_DAT_W-1:0] pat_lo_r;
  logic [CFG_DAT_W-1:0] pat_hi_r;
  logic [COL_W-1:0]     col_r;
  logic [COL_W-1:0]     col_nxt;
  logic [CHAR_W-1:0]    win_r [WIN_D];
  logic [CHAR_W-1:0]    seen [MAX_PATTERN];

  logic             accept;
  logic [COL_W-1:0] col_eff;
  logic             in_line;
  logic             take_byte;
  logic [COL_W:0]   col_inc;
  logic [COL_W:0]   start_full;
  logic             match;
  logic             hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  assign col_eff   = in_line_start ? '0 : col_r;
  assign in_line   = col_eff < COL_W'(MAX_LINE);
  assign take_byte = in_has_byte && in_line;
  assign col_inc   = {1'b0, col_eff} + (COL_W+1)'(1);
  assign start_full = col_inc - (COL_W+1)'(pat_len_r);

  // Newest byte first, then the window of earlier bytes.
  always_comb begin
    seen[0] = in_char_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      seen[i] = win_r[i-1];
    end
  end

  // The pattern ends at the newest byte: byte i back holds pattern byte len-1-i.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < int'(pat_len_r)) begin
        if (seen[i] != pattern_byte(pat_len_r - LEN_W'(1) - LEN_W'(i), pat_lo_r, pat_hi_r)) begin
          match = 1'b0;
        end
      end
    end
  end

  assign hit = take_byte && (pat_len_r != '0) && (int'(pat_len_r) <= MAX_PATTERN) &&
               (col_inc >= (COL_W+1)'(pat_len_r)) && match;

  always_comb begin
    col_nxt = col_r;
    if (accept) begin
      col_nxt = col_eff;
      if (take_byte) begin
        col_nxt = col_inc[COL_W-1:0];
      end
      if (in_line_end) begin
        col_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      col_r     <= '0;
    end else begin
      col_r <= col_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_PATTERN_LEN:  pat_len_r <= cfg_data[LEN_W-1:0];
          REG_PATTERN_LOW:  pat_lo_r  <= cfg_data;
          REG_PATTERN_HIGH: pat_hi_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // The window keeps its contents across lines; the column guard on a hit
  // keeps bytes of an earlier line out of any match.
  always_ff @(posedge clk) begin
    if (accept && take_byte) begin
      win_r[0] <= in_char_byte;
      for (int i = 1; i < WIN_D; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign push                     = accept;
  assign push_item.ctl.line_start = in_line_start;
  assign push_item.ctl.line_end   = in_line_end;
  assign push_item.ctl.backward   = in_backward;
  assign push_item.ctl.hit        = hit;
  assign push_item.bound          = in_bound_col;
  assign push_item.row            = in_row_index;
  assign push_col                 = start_full[COL_W-1:0];

endmodule

// ===== rtl/llps_queue.sv =====
module llps_queue import llps_pkg::*; #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output llps_qstat_t  stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic [PTR_W:0]   count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem[rd_ptr_r];
  assign stat.full  = count_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;

endmodule

// ===== rtl/llps_back.sv =====
module llps_back import llps_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF,
  localparam int COL_W   = $clog2(MAX_LINE + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  llps_item_t           q_item,
  input  logic [COL_W-1:0]     q_col,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [ROW_W-1:0]     out_match_row,
  output logic [OUT_COL_W-1:0] out_match_col
);

  localparam int CMP_W = (COL_W > BOUND_W) ? COL_W : BOUND_W;

  logic                 mode_r;
  logic [BOUND_W-1:0]   bound_r;
  logic [ROW_W-1:0]     row_r;
  logic                 have_r;
  logic [OUT_COL_W-1:0] best_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;

  logic                 eff_mode;
  logic [BOUND_W-1:0]   eff_bound;
  logic [ROW_W-1:0]     eff_row;
  logic                 eff_have;
  logic [OUT_COL_W-1:0] eff_best;
  logic [CMP_W-1:0]     start_x;
  logic [CMP_W-1:0]     bound_x;
  logic                 take;
  logic                 have_new;
  logic [OUT_COL_W-1:0] best_new;

  assign eff_mode  = q_item.ctl.line_start ? q_item.ctl.backward : mode_r;
  assign eff_bound = q_item.ctl.line_start ? q_item.bound : bound_r;
  assign eff_row   = q_item.ctl.line_start ? q_item.row : row_r;
  assign eff_have  = q_item.ctl.line_start ? 1'b0 : have_r;
  assign eff_best  = q_item.ctl.line_start ? '0 : best_r;
  assign start_x   = CMP_W'(q_col);
  assign bound_x   = CMP_W'(eff_bound);

  // Forward keeps the first qualifying start, backward the latest one below the bound.
  always_comb begin
    take = 1'b0;
    if (q_item.ctl.hit) begin
      if (!eff_mode) begin
        take = !eff_have && (start_x >= bound_x);
      end else begin
        take = start_x < bound_x;
      end
    end
  end

  assign have_new = eff_have || take;
  assign best_new = take ? OUT_COL_W'(q_col) : eff_best;

  // Only a line-end word has to wait for the output register.
  assign pop = !q_empty && (!q_item.ctl.line_end || !out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      bound_r     <= '0;
      row_r       <= '0;
      have_r      <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r  <= eff_mode;
        bound_r <= eff_bound;
        row_r   <= eff_row;
        if (q_item.ctl.line_end) begin
          have_r <= 1'b0;
          best_r <= '0;
        end else begin
          have_r <= have_new;
          best_r <= best_new;
        end
      end
      if (pop && q_item.ctl.line_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.ctl.line_end) begin
      out_found_r <= have_new;
      out_row_r   <= eff_row;
      out_col_r   <= have_new ? best_new : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_match_row = out_row_r;
  assign out_match_col = out_col_r;

endmodule

// ===== rtl/line_literal_pattern_search_top.sv =====
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  one byte and line markers
// out_      output     out_valid/out_stall  found, row and column of a line
// cfg_      input      cfg_valid/cfg_ready  register index and write data
//
// One input word is taken every cycle; the window compare decides each byte
// as it arrives, so in_stall rises only when the four-word queue is full.
// A result is written to the output register when the back part pops its
// line-end word; a held out_stall blocks only the next line-end word.
// Reset is synchronous and active low; there is no clearing pass.
module line_literal_pattern_search_top import llps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_LINE    = MAX_LINE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_char_byte,
  input  logic                 in_has_byte,
  input  logic                 in_line_start,
  input  logic                 in_line_end,
  input  logic                 in_backward,
  input  logic [BOUND_W-1:0]   in_bound_col,
  input  logic [ROW_W-1:0]     in_row_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [ROW_W-1:0]     out_match_row,
  output logic [OUT_COL_W-1:0] out_match_col,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

`include "line_literal_pattern_search_top_assert.svh"

  localparam int COL_W = $clog2(MAX_LINE + 1);
  localparam int Q_W   = $bits(llps_item_t) + COL_W;

  logic              push;
  llps_item_t        push_item;
  logic [COL_W-1:0]  push_col;
  logic              q_pop;
  logic [Q_W-1:0]    q_data;
  llps_item_t        q_item;
  logic [COL_W-1:0]  q_col;
  llps_qstat_t       q_stat;

  llps_front #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_LINE   (MAX_LINE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .in_has_byte  (in_has_byte),
    .in_line_start(in_line_start),
    .in_line_end  (in_line_end),
    .in_backward  (in_backward),
    .in_bound_col (in_bound_col),
    .in_row_index (in_row_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_stat.full),
    .push         (push),
    .push_item    (push_item),
    .push_col     (push_col)
  );

  llps_queue #(
    .W(Q_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_item, push_col}),
    .pop      (q_pop),
    .pop_data (q_data),
    .stat     (q_stat)
  );

  assign q_item = q_data[Q_W-1:COL_W];
  assign q_col  = q_data[COL_W-1:0];

  llps_back #(
    .MAX_LINE(MAX_LINE)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_item       (q_item),
    .q_col        (q_col),
    .q_empty      (q_stat.empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_match_row(out_match_row),
    .out_match_col(out_match_col)
  );

  `LLPS_ASSERT_HOLDS(a_queue_status, clk, rst_n, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `LLPS_ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty, "pop from an empty queue")
  `LLPS_ASSERT_IMPLIES(a_miss_col_zero, clk, rst_n, out_valid && !out_found, out_match_col == '0, "column set without a match")
  `LLPS_ASSERT_IMPLIES(a_result_source, clk, rst_n, $rose(out_valid), $past(q_pop && q_item.ctl.line_end), "result without a line-end word")

endmodule
